// ===== rtl/sgps_pkg.sv =====
// Shared types and constants for the sky gradient pixel shader.
// No dependencies; every other file of the block imports this package.
package sgps_pkg;

  // Field widths fixed by the block's interface
  localparam int PIX_W     = 10;
  localparam int DIM_W     = 11;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd400;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd225;

  // Ray direction: signed components, magnitudes and squares
  localparam int DIR_W = 13;   // 2*col+1-W over the full 11-bit dimension range
  localparam int SQ_W  = 22;   // square of an 11-bit magnitude
  localparam int LEN_W = 24;   // sum of three squares

  // Unit vertical component search, Q1.16 magnitude 0..65536
  localparam int MAG_W      = 17;
  localparam int QBITS      = 17;
  localparam int FRAC_SHIFT = 32;  // target = dy^2 * 2^32
  localparam int RES_W      = 58;  // residual and running q*len2 products
  localparam logic [MAG_W-1:0] ONE_Q16 = 17'd65536;

  // Blend and byte conversion
  localparam int A_W         = 17;
  localparam int RED_N_W     = 18;
  localparam int RED_SHIFT   = 9;
  localparam int GREEN_N_W   = 20;
  localparam int GREEN_SC_W  = 18;
  localparam int GREEN_M_W   = 38;
  localparam int GREEN_SHIFT = 17;
  localparam int GREEN_K_W   = 21;
  localparam int GREEN_R_W   = 22;
  localparam int GREEN_P_W   = 43;
  localparam int GREEN_RSH   = 34;

  localparam logic [RED_N_W-1:0]    RED_BASE    = 18'd131072;
  localparam logic [GREEN_N_W-1:0]  GREEN_BASE  = 20'd655360;
  localparam logic [GREEN_SC_W-1:0] GREEN_SCALE = 18'd255999;
  // ceil(2^34 / 5000): exact floor division by 5000 for any 21-bit value
  localparam logic [GREEN_R_W-1:0]  GREEN_RECIP = 22'd3435974;
  localparam logic [BYTE_W-1:0]     BYTE_FULL   = 8'd255;

  typedef struct packed {
    logic [LEN_W-1:0] len2;
    logic [SQ_W-1:0]  num_sq;
    logic             dy_neg;
  } ray_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             dy_neg;
  } unit_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
  } shade_t;

endpackage

// ===== rtl/sgps_intf.sv =====
// Handshake channels of the sky gradient pixel shader: pixel, color, config.
// Depends on sgps_pkg for the field widths.
interface sgps_pix_if;
  import sgps_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_row;
  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface sgps_rgb_if;
  import sgps_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface sgps_cfg_if;
  import sgps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sky_gradient_pixel_shader_top.sv =====
// Top level of the sky gradient pixel shader: configuration registers,
// pipeline stages and the output register with skid. Depends on sgps_pkg,
// sgps_intf, sgps_ray, sgps_norm and sgps_blend.

// The shader takes one pixel (pixel_col, pixel_row) per item and returns one
// color item: white blended toward (0.5, 0.7, 1.0) by how far the camera ray
// through that pixel points up, as 8-bit red, green and blue (blue always 255).
// Image width and height are set through the cfg channel (index 0 and 1);
// zero is held as 1 and values above MAX_DIM as MAX_DIM. Write them only while
// no pixel is in flight. While the output is taken every clock, the pipeline
// takes one pixel every clock and returns one color every clock. Each pixel
// passes 24 registers: 3 stages of ray setup, 17 stages of the bit-per-stage
// search for the unit vertical component, 3 stages of blend and byte
// conversion, and the output register. The search makes up most of that
// depth. When the output stalls, a one-item skid holds the result that
// was already in flight and the pixel input drops ready until the skid drains.

module sky_gradient_pixel_shader_top #(
  parameter int MAX_DIM = 1024
) (
  input  logic       clk,
  input  logic       rst,
  sgps_cfg_if.sink   cfg,
  sgps_pix_if.sink   pix,
  sgps_rgb_if.source color
);
  import sgps_pkg::*;

  // configuration
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] cfg_dim;

  // pipeline control: the whole pipe moves while the skid is empty
  logic   adv;
  logic   ray_valid;
  ray_t   ray;
  logic   unit_valid;
  unit_t  unit_dir;
  logic   shade_valid;
  shade_t shade;

  // output register and skid
  logic   out_valid;
  shade_t out_shade;
  logic   skid_valid;
  shade_t skid_shade;

  assign cfg.ready = 1'b1;

  // clamp the written dimension into 1..MAX_DIM
  always_comb begin
    if (cfg.data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (int'(cfg.data) > MAX_DIM) begin
      cfg_dim = DIM_W'(MAX_DIM);
    end else begin
      cfg_dim = cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_dim;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_dim;
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  assign adv       = !skid_valid;
  assign pix.ready = adv;

  // ray direction and squared length
  sgps_ray u_ray (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (pix.valid),
    .pixel_col    (pix.pixel_col),
    .pixel_row    (pix.pixel_row),
    .image_width  (image_width),
    .image_height (image_height),
    .out_valid    (ray_valid),
    .out_ray      (ray)
  );

  // normalized vertical component, Q1.16
  sgps_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (ray_valid),
    .in_ray    (ray),
    .out_valid (unit_valid),
    .out_unit  (unit_dir)
  );

  // blend factor and color bytes
  sgps_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (unit_valid),
    .in_unit   (unit_dir),
    .out_valid (shade_valid),
    .out_shade (shade)
  );

  // Output register with a one-item skid. The skid fills only when a new
  // result arrives while the output holds an item that is not being taken;
  // it empties into the output register on the next take.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (color.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (shade_valid) begin
      if (!out_valid || color.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (color.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (color.ready) begin
        out_shade <= skid_shade;
      end
    end else if (shade_valid) begin
      if (!out_valid || color.ready) begin
        out_shade <= shade;
      end else begin
        skid_shade <= shade;
      end
    end
  end

  assign color.valid = out_valid;
  assign color.red   = out_shade.red;
  assign color.green = out_shade.green;
  assign color.blue  = BYTE_FULL;

`ifndef NO_ASSERTIONS
  // the skid only ever holds an item behind a waiting output item
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output register is empty");

  // the skid fills only from a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !color.ready))
    else $error("skid filled while the output was free");

  // a take drains the skid, since the pipe is frozen while it is full
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && color.ready) |=> !skid_valid)
    else $error("skid did not drain after a take");

  // the blend toward light blue never lowers green below red
  a_green_over_red: assert property (@(posedge clk) disable iff (rst)
    color.valid |-> (color.green >= color.red))
    else $error("green byte below red byte");
`endif

endmodule

// ===== rtl/sgps_ray.sv =====
// Ray setup: direction components, their squares and the squared length.
// Three register stages; depends on sgps_pkg.
module sgps_ray (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [sgps_pkg::PIX_W-1:0] pixel_col,
  input  logic [sgps_pkg::PIX_W-1:0] pixel_row,
  input  logic [sgps_pkg::DIM_W-1:0] image_width,
  input  logic [sgps_pkg::DIM_W-1:0] image_height,
  output logic                      out_valid,
  output sgps_pkg::ray_t            out_ray
);
  import sgps_pkg::*;

  logic signed [DIR_W-1:0] dx;
  logic signed [DIR_W-1:0] dy;
  logic [DIR_W-1:0]        dx_mag;
  logic [DIR_W-1:0]        dy_mag;

  logic             s1_valid;
  logic [DIM_W-1:0] ax;
  logic [DIM_W-1:0] ay;
  logic [DIM_W-1:0] az;
  logic             s1_neg;

  logic            s2_valid;
  logic [SQ_W-1:0] ax_sq;
  logic [SQ_W-1:0] ay_sq;
  logic [SQ_W-1:0] az_sq;
  logic            s2_neg;

  always_comb begin
    dx     = $signed({2'b00, pixel_col, 1'b1}) - $signed({2'b00, image_width});
    dy     = $signed({2'b00, image_height}) - $signed({2'b00, pixel_row, 1'b1});
    dx_mag = dx[DIR_W-1] ? (DIR_W'(0) - DIR_W'(dx)) : DIR_W'(dx);
    dy_mag = dy[DIR_W-1] ? (DIR_W'(0) - DIR_W'(dy)) : DIR_W'(dy);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ax     <= dx_mag[DIM_W-1:0];
      ay     <= dy_mag[DIM_W-1:0];
      az     <= image_height;
      s1_neg <= dy[DIR_W-1];

      ax_sq  <= SQ_W'(ax) * SQ_W'(ax);
      ay_sq  <= SQ_W'(ay) * SQ_W'(ay);
      az_sq  <= SQ_W'(az) * SQ_W'(az);
      s2_neg <= s1_neg;

      out_ray.len2   <= LEN_W'(ax_sq) + LEN_W'(ay_sq) + LEN_W'(az_sq);
      out_ray.num_sq <= ay_sq;
      out_ray.dy_neg <= s2_neg;
    end
  end

endmodule

// ===== rtl/sgps_norm.sv =====
// Unit vertical component: bit-by-bit search for the largest q with
// q*q*len2 <= dy^2 * 2^32, one result bit per register stage. Depends on sgps_pkg.
module sgps_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  sgps_pkg::ray_t in_ray,
  output logic           out_valid,
  output sgps_pkg::unit_t out_unit
);
  import sgps_pkg::*;

  // stage k holds the state after deciding bit QBITS-1-k
  logic             v    [QBITS];
  logic [RES_W-1:0] res  [QBITS];  // target minus q^2 * len2
  logic [RES_W-1:0] qlen [QBITS];  // q * len2
  logic [MAG_W-1:0] q    [QBITS];
  logic [LEN_W-1:0] len  [QBITS];
  logic             neg  [QBITS];

  genvar k;
  generate
    for (k = 0; k < QBITS; k++) begin : g_step
      localparam int B = QBITS - 1 - k;

      logic             v_in;
      logic [RES_W-1:0] res_in;
      logic [RES_W-1:0] qlen_in;
      logic [MAG_W-1:0] q_in;
      logic [LEN_W-1:0] len_in;
      logic             neg_in;
      logic [RES_W-1:0] sub;
      logic             take;

      if (k == 0) begin : g_first
        assign v_in    = in_valid;
        assign res_in  = RES_W'(in_ray.num_sq) << FRAC_SHIFT;
        assign qlen_in = '0;
        assign q_in    = '0;
        assign len_in  = in_ray.len2;
        assign neg_in  = in_ray.dy_neg;
      end else begin : g_next
        assign v_in    = v[k-1];
        assign res_in  = res[k-1];
        assign qlen_in = qlen[k-1];
        assign q_in    = q[k-1];
        assign len_in  = len[k-1];
        assign neg_in  = neg[k-1];
      end

      // (q + 2^B)^2 * len2 - q^2 * len2 = q*len2*2^(B+1) + len2*2^(2B)
      always_comb begin
        sub  = (qlen_in << (B + 1)) + (RES_W'(len_in) << (2 * B));
        // a zero length cannot fit any bit; keep q within 1.0
        take = (len_in != '0) && (sub <= res_in) &&
               ((B == QBITS - 1) || !q_in[MAG_W-1]);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (adv) begin
          v[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          res[k]  <= take ? (res_in - sub) : res_in;
          qlen[k] <= take ? (qlen_in + (RES_W'(len_in) << B)) : qlen_in;
          q[k]    <= take ? (q_in | (MAG_W'(1) << B)) : q_in;
          len[k]  <= len_in;
          neg[k]  <= neg_in;
        end
      end
    end
  endgenerate

  assign out_valid       = v[QBITS-1];
  assign out_unit.mag    = q[QBITS-1];
  assign out_unit.dy_neg = neg[QBITS-1];

endmodule

// ===== rtl/sgps_blend.sv =====
// Blend factor and byte conversion of red and green.
// Three register stages with two constant multipliers; depends on sgps_pkg.
module sgps_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  sgps_pkg::unit_t in_unit,
  output logic            out_valid,
  output sgps_pkg::shade_t out_shade
);
  import sgps_pkg::*;

  logic [MAG_W:0]     a_sum;
  logic [A_W-1:0]     a_q;
  logic [RED_N_W-1:0] red_n;
  logic [RED_N_W-RED_SHIFT-1:0] red_w;
  logic [GREEN_N_W-1:0] green_n;
  logic [GREEN_M_W-1:0] green_m;
  logic [GREEN_P_W-1:0] green_p;
  logic [GREEN_P_W-GREEN_RSH-1:0] green_w;

  logic                 s1_valid;
  logic [BYTE_W-1:0]    s1_red;
  logic [GREEN_N_W-1:0] s1_gn;

  logic                 s2_valid;
  logic [BYTE_W-1:0]    s2_red;
  logic [GREEN_K_W-1:0] s2_gk;

  always_comb begin
    a_sum = in_unit.dy_neg ? ({1'b0, ONE_Q16} - {1'b0, in_unit.mag})
                           : ({1'b0, ONE_Q16} + {1'b0, in_unit.mag});
    a_q   = a_sum[MAG_W:1];
    // 255999*n/131072000 = n/512 less at most 0.001: borrow only on exact multiples
    red_n = RED_BASE - RED_N_W'(a_q);
    red_w = red_n[RED_N_W-1:RED_SHIFT] -
            (RED_N_W - RED_SHIFT)'(red_n[RED_SHIFT-1:0] == '0);
    green_n = GREEN_BASE - (GREEN_N_W'({a_q, 1'b0}) + GREEN_N_W'(a_q));
    green_m = GREEN_M_W'(s1_gn) * GREEN_M_W'(GREEN_SCALE);
    // divide by 2^17 * 5000: shift, then reciprocal multiply
    green_p = GREEN_P_W'(s2_gk) * GREEN_P_W'(GREEN_RECIP);
    green_w = green_p[GREEN_P_W-1:GREEN_RSH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_red <= (red_w > (RED_N_W - RED_SHIFT)'(BYTE_FULL)) ? BYTE_FULL : red_w[BYTE_W-1:0];
      s1_gn  <= green_n;

      s2_red <= s1_red;
      s2_gk  <= green_m[GREEN_M_W-1:GREEN_SHIFT];

      out_shade.red   <= s2_red;
      out_shade.green <= (green_w > (GREEN_P_W - GREEN_RSH)'(BYTE_FULL)) ?
                         BYTE_FULL : green_w[BYTE_W-1:0];
    end
  end

endmodule

// ===== dv/tb_sky_gradient_pixel_shader_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sky gradient pixel shader: pixels in, colors out.
// Depends on sgps_pkg, the sgps_intf channel interfaces and the shader RTL.

module tb_sky_gradient_pixel_shader_top;
  import sgps_pkg::*;

  localparam int MAX_DIM        = 1024;
  localparam int PIPE_LATENCY   = 23;     // pixel accepted to color valid
  localparam int HOLDOFF_CYCLES = 90;     // long sink stall, well past the pipe depth
  localparam int DRAIN_LIMIT    = 5000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_PIXELS   = 50;

  // Indexes past the two registers; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // One expected color, tagged with the pixel that produced it
  typedef struct packed {
    logic [PIX_W-1:0]  pix_col;
    logic [PIX_W-1:0]  pix_row;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  logic clk;
  logic rst;

  sgps_cfg_if cfg_ch ();
  sgps_pix_if pix_ch ();
  sgps_rgb_if rgb_ch ();

  sky_gradient_pixel_shader_top #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .pix  (pix_ch),
    .color(rgb_ch)
  );

  // Shadow copy of the two dimension registers, as the block should hold them
  logic [DIM_W-1:0] cur_width;
  logic [DIM_W-1:0] cur_height;

  // Colors owed by the block, oldest first
  rgb_t pending_colors[$];

  int  error_count    = 0;
  int  pixels_sent    = 0;
  int  reg_writes     = 0;
  int  settings_used  = 0;
  int  colors_checked = 0;
  bit  idle_on        = 1'b0;   // random gaps on both sides
  logic sink_hold     = 1'b0;   // long sink stall in progress
  logic holdoff_go    = 1'b0;   // request one long sink stall

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A dimension register keeps 1 for a zero write and MAX_DIM above that.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > MAX_DIM) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  // Color for one pixel under the current width and height. The ray
  // (2c+1-W, H-2r-1, -H) is normalized on its vertical axis by a bitwise
  // search for the largest Q1.16 magnitude q with q^2*|d|^2 <= dy^2*2^32.
  function automatic rgb_t shade_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    longint col_i, row_i, w_i, h_i, dx, dy;
    longint unsigned ax, ay, len2, target, q, cand, a_q, red_v, green_v;
    rgb_t c;
    col_i = col;
    row_i = row;
    w_i   = cur_width;
    h_i   = cur_height;
    dx    = 2 * col_i + 1 - w_i;
    dy    = h_i - 2 * row_i - 1;
    ax    = (dx < 0) ? -dx : dx;
    ay    = (dy < 0) ? -dy : dy;
    len2  = ax * ax + ay * ay + h_i * h_i;
    target = (ay * ay) << 32;
    q = 0;
    // A zero-length ray cannot happen (dz is never zero); treat it as level.
    if (len2 != 0) begin
      for (int b = 16; b >= 0; b--) begin
        cand = q | (64'd1 << b);
        if (cand <= ONE_Q16 && cand * cand * len2 <= target) q = cand;
      end
    end
    a_q = (dy < 0) ? (ONE_Q16 - q) >> 1 : (ONE_Q16 + q) >> 1;
    red_v   = (64'd255999 * (64'd131072 - a_q)) / 64'd131072000;
    green_v = (64'd255999 * (64'd655360 - 3 * a_q)) / 64'd655360000;
    c.pix_col = col;
    c.pix_row = row;
    c.red     = (red_v > 255) ? 8'd255 : red_v[BYTE_W-1:0];
    c.green   = (green_v > 255) ? 8'd255 : green_v[BYTE_W-1:0];
    c.blue    = BYTE_FULL;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Compare every accepted color with the oldest one still owed. Values are
  // sampled at the edge, before this edge's updates land.
  always @(posedge clk) begin : color_check
    rgb_t want;
    if (!rst && rgb_ch.valid && rgb_ch.ready) begin
      if (pending_colors.size() == 0) begin
        flag_mismatch($sformatf("color %0d/%0d/%0d arrived with no pixel pending",
                                rgb_ch.red, rgb_ch.green, rgb_ch.blue));
      end else begin
        want = pending_colors.pop_front();
        colors_checked++;
        if (rgb_ch.red !== want.red)
          flag_mismatch($sformatf("pixel (%0d,%0d) red %0d, expected %0d",
                                  want.pix_col, want.pix_row, rgb_ch.red, want.red));
        if (rgb_ch.green !== want.green)
          flag_mismatch($sformatf("pixel (%0d,%0d) green %0d, expected %0d",
                                  want.pix_col, want.pix_row, rgb_ch.green, want.green));
        if (rgb_ch.blue !== want.blue)
          flag_mismatch($sformatf("pixel (%0d,%0d) blue %0d, expected %0d",
                                  want.pix_col, want.pix_row, rgb_ch.blue, want.blue));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Color sink: random stall bursts while idling is on, and
  // a forced stall whenever the long hold-off runs.
  // --------------------------------------------------------------------------
  initial begin : color_sink
    int stall_left;
    stall_left   = 0;
    rgb_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        rgb_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rgb_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        rgb_ch.ready <= 1'b0;
      end else begin
        rgb_ch.ready <= 1'b1;
      end
    end
  end

  // Long sink hold-off, counted here so the sender keeps pushing meanwhile
  initial begin : sink_holdoff
    forever begin
      do @(posedge clk); while (!holdoff_go);
      holdoff_go <= 1'b0;
      sink_hold  <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clk);
      sink_hold  <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one pixel and hold it until accepted; record the color it owes.
  // Enter and leave at a rising edge.
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid     <= 1'b1;
    pix_ch.pixel_col <= col;
    pix_ch.pixel_row <= row;
    do @(posedge clk); while (!pix_ch.ready);
    pending_colors.push_back(shade_pixel(col, row));
    pixels_sent++;
  endtask

  // Mostly pixels inside the current image, the rest anywhere in the field
  task automatic send_random_pixel();
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    if ($urandom_range(0, 3) != 0) begin
      col = PIX_W'($urandom_range(0, cur_width - 1));
      row = PIX_W'($urandom_range(0, cur_height - 1));
    end else begin
      col = PIX_W'($urandom_range(0, 1023));
      row = PIX_W'($urandom_range(0, 1023));
    end
    send_pixel(col, row);
  endtask

  // Drop valid and wait until every owed color has come back
  task automatic drain_pipeline();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the shadow copy follows at the accepting edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_IMAGE_WIDTH:  cur_width  = clamp_dim(value);
      REG_IMAGE_HEIGHT: cur_height = clamp_dim(value);
      default: ;  // spare index: ignored
    endcase
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    drain_pipeline();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset dimensions 400x225: corners, the odd-height horizon row where the
  // ray is level, and the column pair around the center.
  task automatic test_reset_image();
    settings_used++;
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd399, 10'd224);
    send_pixel(10'd200, 10'd112);
    send_pixel(10'd199, 10'd112);
  endtask

  // Field extremes and alternating bit patterns, all of them outside the image
  task automatic test_field_extremes();
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'h155, 10'h2AA);
  endtask

  // Zero dimensions hold 1, oversized ones hold MAX_DIM, spare indexes are
  // ignored, and the 1-pixel and full-size extremes on each axis.
  task automatic test_dimension_limits();
    set_image(11'd0, 11'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);

    set_image(11'd2047, 11'd1025);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd511, 10'd511);
    send_pixel(10'd512, 10'd512);

    drain_pipeline();
    write_reg(REG_SPARE_LO, 11'd5);
    write_reg(REG_SPARE_HI, 11'd2047);
    send_pixel(10'd511, 10'd511);

    set_image(11'd1024, 11'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);

    set_image(11'd1, 11'd1024);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd0, 10'd511);
  endtask

  // Random pixels under a sequence of image sizes, extremes first
  task automatic test_random_images();
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    idle_on = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin w = 11'd1024; h = 11'd1024; end
        1: begin w = 11'd1;    h = 11'd1;    end
        2: begin
          w = DIM_W'($urandom_range(0, 2047));
          h = DIM_W'($urandom_range(0, 2047));
        end
        default: begin
          w = DIM_W'($urandom_range(1, MAX_DIM));
          h = DIM_W'($urandom_range(1, MAX_DIM));
        end
      endcase
      set_image(w, h);
      repeat (PHASE_PIXELS) send_random_pixel();
    end
  endtask

  // Stall the sink for a long stretch while pixels keep coming, so the
  // pipeline and its skid fill and the pixel input has to drop ready.
  task automatic test_backpressure();
    set_image(11'd400, 11'd225);
    idle_on = 1'b0;
    holdoff_go <= 1'b1;
    repeat (80) send_random_pixel();
  endtask

  // Last stretch: both sides at full rate, one pixel and one color per clock
  task automatic test_full_rate();
    set_image(DIM_W'($urandom_range(1, MAX_DIM)), DIM_W'($urandom_range(1, MAX_DIM)));
    idle_on = 1'b0;
    repeat (70) send_random_pixel();
  endtask

  // Wait out the owed colors, watch a little longer for strays, then report
  task automatic finish_run();
    int waited;
    waited = 0;
    pix_ch.valid <= 1'b0;
    while (pending_colors.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_colors.size() != 0)
      flag_mismatch($sformatf("%0d colors never arrived", pending_colors.size()));
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    $display("Shaded %0d pixels (%0d colors checked) over %0d image sizes,",
             pixels_sent, colors_checked, settings_used);
    $display("with %0d register writes, sink hold-off and random idling.", reg_writes);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero
    rst              = 1'b1;
    pix_ch.valid     = 1'b0;
    pix_ch.pixel_col = '0;
    pix_ch.pixel_row = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_IMAGE_WIDTH;
    cfg_ch.data      = '0;
    cur_width        = WIDTH_RESET;
    cur_height       = HEIGHT_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_image();
    test_field_extremes();
    test_dimension_limits();
    test_random_images();
    test_backpressure();
    test_full_rate();
    finish_run();
  end

endmodule

// ===== sim.f =====
rtl/sgps_pkg.sv
rtl/sgps_intf.sv
rtl/sgps_ray.sv
rtl/sgps_norm.sv
rtl/sgps_blend.sv
rtl/sky_gradient_pixel_shader_top.sv
dv/tb_sky_gradient_pixel_shader_top.sv
